@@ rtl/core/srhm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the stream rate health monitor.
package srhm_pkg;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [1:0] HEALTH_GOOD     = 2'd0;
  localparam logic [1:0] HEALTH_DEGRADED = 2'd1;
  localparam logic [1:0] HEALTH_CRITICAL = 2'd2;

  localparam logic [2:0] REG_FPS_DELTA  = 3'd0;
  localparam logic [2:0] REG_EMIT_MS    = 3'd1;
  localparam logic [2:0] REG_LAT_DELTA  = 3'd2;
  localparam logic [2:0] REG_FPS_CRIT   = 3'd3;
  localparam logic [2:0] REG_FPS_DEGR   = 3'd4;
  localparam logic [2:0] REG_DROP_CRIT  = 3'd5;
  localparam logic [2:0] REG_DROP_DEGR  = 3'd6;

  localparam int unsigned FPS_SCALE = 256000;
  localparam logic [22:0] FPS_MAX = 23'h7FFFFF;
  localparam logic signed [24:0] LAT_UNKNOWN = -25'sd256;

  // Result word, first member in the highest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic signed [24:0] latency_out;
    logic              latency_emit;
    logic [31:0]       drops;
    logic              drops_emit;
    logic [1:0]        health;
    logic              health_emit;
    logic [22:0]       fps_q8;
    logic              fps_emit;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

@@ rtl/core/srhm_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
module srhm_div #(
  parameter int NUM_W = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [31:0]          den,
  output srhm_pkg::div_ctl_t   ctl,
  output logic [NUM_W-1:0]     quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [32:0]      rem;
  logic [NUM_W-1:0] dq;
  logic [31:0]      den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [32:0]      rem_sh;
  logic             take;

  assign rem_sh = {rem[31:0], dq[NUM_W-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dq    <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= take ? rem_sh - {1'b0, den_r} : rem_sh;
      dq  <= {dq[NUM_W-2:0], take};
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
  assign quot      = dq;

endmodule

@@ rtl/core/stream_rate_health_monitor_unit.sv @@
`timescale 1ns / 1ps
// Top level: stream rate and health monitor with frame-time and snapshot memories.
// Frame items can follow back to back; a tick with a rate passes through S_RD, S_SPAN,
// S_DIV (the bit-serial rate divider), S_MUL and S_CLASS, then S_OUT if it reports;
// a tick without a rate skips S_DIV, an idle tick stays in S_IDLE, a reset item goes
// straight to S_OUT, and a full output register holds S_OUT until it frees up.
// One item is worked at a time; a new one is taken while a result waits at the output.
// rst is synchronous and clears control state and counters; memory contents are
// left as they are and are only read after being written, tracked by fill counts.
module stream_rate_health_monitor_unit #(
  parameter int FPS_WINDOW  = 32,
  parameter int DROP_WINDOW = 16
) (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // time_ms[31:0], source_present[32], frame_count[64:33],
                                 // dropped_count[96:65], latency_q8[120:97], zeros above
  input  logic [1:0]   s_tuser,  // op
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [87:0]  m_tdata,  // fps_emit[0], fps_q8[23:1], health_emit[24],
                                 // health[26:25], drops_emit[27], drops[59:28],
                                 // latency_emit[60], latency_out[85:61], zeros above
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int PTR_W  = $clog2(FPS_WINDOW);
  localparam int FILL_W = $clog2(FPS_WINDOW + 1);
  localparam int SPTR_W = $clog2(DROP_WINDOW);
  localparam int SFILL_W = $clog2(DROP_WINDOW + 1);
  localparam int NUM_W  = $clog2((FPS_WINDOW - 1) * 256000 + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SPAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CLASS = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // ---------------- configuration registers ----------------
  logic [15:0] fps_change_delta, emit_interval_ms, latency_change_delta;
  logic [15:0] fps_critical, fps_degraded, drop_critical, drop_degraded;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fps_change_delta     <= 16'd26;
      emit_interval_ms     <= 16'd500;
      latency_change_delta <= 16'd128;
      fps_critical         <= 16'd1280;
      fps_degraded         <= 16'd3840;
      drop_critical        <= 16'd13107;
      drop_degraded        <= 16'd3277;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        srhm_pkg::REG_FPS_DELTA: fps_change_delta     <= pwdata[15:0];
        srhm_pkg::REG_EMIT_MS:   emit_interval_ms     <= pwdata[15:0];
        srhm_pkg::REG_LAT_DELTA: latency_change_delta <= pwdata[15:0];
        srhm_pkg::REG_FPS_CRIT:  fps_critical         <= pwdata[15:0];
        srhm_pkg::REG_FPS_DEGR:  fps_degraded         <= pwdata[15:0];
        srhm_pkg::REG_DROP_CRIT: drop_critical        <= pwdata[15:0];
        srhm_pkg::REG_DROP_DEGR: drop_degraded        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      srhm_pkg::REG_FPS_DELTA: prdata = {16'd0, fps_change_delta};
      srhm_pkg::REG_EMIT_MS:   prdata = {16'd0, emit_interval_ms};
      srhm_pkg::REG_LAT_DELTA: prdata = {16'd0, latency_change_delta};
      srhm_pkg::REG_FPS_CRIT:  prdata = {16'd0, fps_critical};
      srhm_pkg::REG_FPS_DEGR:  prdata = {16'd0, fps_degraded};
      srhm_pkg::REG_DROP_CRIT: prdata = {16'd0, drop_critical};
      srhm_pkg::REG_DROP_DEGR: prdata = {16'd0, drop_degraded};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------- input unpacking ----------------
  logic [31:0] in_time, in_frames, in_drops;
  logic        in_present;
  logic [23:0] in_lat;
  assign in_time    = s_tdata[31:0];
  assign in_present = s_tdata[32];
  assign in_frames  = s_tdata[64:33];
  assign in_drops   = s_tdata[96:65];
  assign in_lat     = s_tdata[120:97];

  // ---------------- state ----------------
  logic [2:0]          state;
  logic [PTR_W-1:0]    head;
  logic [FILL_W-1:0]   fill;
  logic [SPTR_W-1:0]   snap_head;
  logic [SFILL_W-1:0]  snap_fill;
  logic [31:0]         time_base, last_fps_time, last_latency_time;
  logic [31:0]         last_tick_frames, last_drops;
  logic [22:0]         last_fps;
  logic signed [24:0]  last_latency;
  logic [1:0]          health_state;

  // latched tick request
  logic [31:0] t_l, frames_l, drops_l;
  logic        present_l;
  logic [23:0] lat_l;
  logic        snap_two;

  logic [31:0] newest_t;
  logic [63:0] snap_old;
  logic [22:0] fps_val;
  logic        positive;
  logic [47:0] prod_c, prod_d, dshift;
  logic        fspan_nz;

  srhm_pkg::out_item_t pend, out_r;
  logic                out_valid;

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ---------------- index arithmetic ----------------
  logic [PTR_W+1:0]  newest_raw, oldest_raw;
  logic [PTR_W-1:0]  newest_idx, oldest_idx, head_inc;
  logic [SPTR_W-1:0] snap_head_next;
  logic [SFILL_W-1:0] snap_fill_next;
  logic [SPTR_W+1:0] sold_raw;
  logic [SPTR_W-1:0] sold_idx;

  assign newest_raw = (PTR_W+2)'(head) + (PTR_W+2)'(FPS_WINDOW - 1);
  assign newest_idx = (newest_raw >= (PTR_W+2)'(FPS_WINDOW)) ?
                      PTR_W'(newest_raw - (PTR_W+2)'(FPS_WINDOW)) : PTR_W'(newest_raw);
  assign oldest_raw = (PTR_W+2)'(head) + (PTR_W+2)'(FPS_WINDOW) - (PTR_W+2)'(fill);
  assign oldest_idx = (oldest_raw >= (PTR_W+2)'(FPS_WINDOW)) ?
                      PTR_W'(oldest_raw - (PTR_W+2)'(FPS_WINDOW)) : PTR_W'(oldest_raw);
  assign head_inc   = (head == PTR_W'(FPS_WINDOW - 1)) ? '0 : head + 1'b1;

  assign snap_head_next = (snap_head == SPTR_W'(DROP_WINDOW - 1)) ? '0 : snap_head + 1'b1;
  assign snap_fill_next = (snap_fill < SFILL_W'(DROP_WINDOW)) ? snap_fill + 1'b1 : snap_fill;
  // oldest snapshot after this tick's write
  assign sold_raw = (SPTR_W+2)'(snap_head_next) + (SPTR_W+2)'(DROP_WINDOW)
                    - (SPTR_W+2)'(snap_fill_next);
  assign sold_idx = (sold_raw >= (SPTR_W+2)'(DROP_WINDOW)) ?
                    SPTR_W'(sold_raw - (SPTR_W+2)'(DROP_WINDOW)) : SPTR_W'(sold_raw);

  // ---------------- idle skip ----------------
  logic [31:0] cur_frames;
  logic        skip;
  assign cur_frames = in_present ? in_frames : 32'd0;
  assign skip = (cur_frames == last_tick_frames) && (health_state == srhm_pkg::HEALTH_GOOD);

  logic tick_go;
  assign tick_go = accept && (s_tuser == srhm_pkg::OP_TICK) && !skip;

  // ---------------- memories ----------------
  logic [31:0]      time_mem [FPS_WINDOW];
  logic [31:0]      time_q;
  logic [PTR_W-1:0] time_raddr;
  logic [63:0]      snap_mem [DROP_WINDOW];
  logic [63:0]      snap_q;

  // newest address while waiting for a tick, oldest in S_RD
  assign time_raddr = (state == S_RD) ? oldest_idx : newest_idx;

  always_ff @(posedge clk) begin
    if (accept && s_tuser == srhm_pkg::OP_FRAME) begin
      time_mem[head] <= in_time;
    end
    time_q <= time_mem[time_raddr];
  end

  always_ff @(posedge clk) begin
    if (tick_go && in_present) begin
      snap_mem[snap_head] <= {in_drops, in_frames};
    end
    snap_q <= snap_mem[sold_idx];
  end

  // ---------------- divider ----------------
  srhm_pkg::div_ctl_t div_ctl;
  logic [NUM_W-1:0]   quot;
  logic [31:0]        span;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;

  assign span      = newest_t - time_q;
  assign div_start = (state == S_SPAN) && (fill >= FILL_W'(2)) && (span != 32'd0);
  assign div_num   = NUM_W'((fill - 1'b1) * srhm_pkg::FPS_SCALE);

  srhm_div #(.NUM_W(NUM_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (span),
    .ctl  (div_ctl),
    .quot (quot)
  );

  // ---------------- drop spans ----------------
  logic [31:0] fspan, dspan;
  assign fspan = snap_two ? frames_l - snap_old[31:0]  : 32'd0;
  assign dspan = snap_two ? drops_l  - snap_old[63:32] : 32'd0;

  // ---------------- classification and debounce ----------------
  logic [31:0]        now;
  logic [22:0]        fps_d;
  logic               fe, he, de, le;
  logic [1:0]         health_new;
  logic               rc, rd;
  logic [31:0]        cur_drops;
  logic signed [25:0] lat_d;
  logic [25:0]        lat_abs;

  assign now  = t_l - time_base;
  assign fps_d = (fps_val > last_fps) ? fps_val - last_fps : last_fps - fps_val;
  assign fe = (fps_d >= 23'(fps_change_delta)) ||
              ((now - last_fps_time) >= 32'(emit_interval_ms));
  assign rc = fspan_nz && (dshift > prod_c);
  assign rd = fspan_nz && (dshift > prod_d);

  always_comb begin
    health_new = srhm_pkg::HEALTH_GOOD;
    if (present_l) begin
      if (positive) begin
        if (fps_val < 23'(fps_critical) || rc) begin
          health_new = srhm_pkg::HEALTH_CRITICAL;
        end else if (fps_val < 23'(fps_degraded) || rd) begin
          health_new = srhm_pkg::HEALTH_DEGRADED;
        end
      end else if (frames_l != 32'd0) begin
        health_new = srhm_pkg::HEALTH_CRITICAL;
      end
    end
  end

  assign he = (health_new != health_state);
  assign cur_drops = present_l ? drops_l : 32'd0;
  assign de = (cur_drops != last_drops);
  assign lat_d   = $signed({2'b00, lat_l}) - 26'(last_latency);
  assign lat_abs = lat_d[25] ? 26'(-lat_d) : 26'(lat_d);
  assign le = present_l && ((lat_abs > 26'(latency_change_delta)) ||
              ((now - last_latency_time) >= 32'(emit_interval_ms)));

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      head              <= '0;
      fill              <= '0;
      snap_head         <= '0;
      snap_fill         <= '0;
      time_base         <= '0;
      last_fps          <= '0;
      last_fps_time     <= '0;
      last_latency      <= srhm_pkg::LAT_UNKNOWN;
      last_latency_time <= '0;
      health_state      <= srhm_pkg::HEALTH_GOOD;
      last_tick_frames  <= '0;
      last_drops        <= '0;
      out_valid         <= 1'b0;
    end else begin
      // S_OUT only leaves once the output register is free or being drained
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_valid && m_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (s_tuser)
              srhm_pkg::OP_FRAME: begin
                head <= head_inc;
                if (fill < FILL_W'(FPS_WINDOW)) fill <= fill + 1'b1;
              end
              srhm_pkg::OP_TICK: begin
                last_tick_frames <= cur_frames;
                if (!skip) begin
                  if (in_present) begin
                    snap_head <= snap_head_next;
                    snap_fill <= snap_fill_next;
                  end
                  state <= S_RD;
                end
              end
              srhm_pkg::OP_RESET: begin
                head              <= '0;
                fill              <= '0;
                snap_head         <= '0;
                snap_fill         <= '0;
                time_base         <= in_time;
                last_fps          <= '0;
                last_fps_time     <= '0;
                last_latency      <= srhm_pkg::LAT_UNKNOWN;
                last_latency_time <= '0;
                health_state      <= srhm_pkg::HEALTH_GOOD;
                last_tick_frames  <= '0;
                last_drops        <= '0;
                state             <= S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_RD:   state <= S_SPAN;
        S_SPAN: state <= div_start ? S_DIV : S_MUL;
        S_DIV:  if (div_ctl.done) state <= S_MUL;
        S_MUL:  state <= S_CLASS;
        S_CLASS: begin
          if (fe) begin
            last_fps      <= fps_val;
            last_fps_time <= now;
          end
          if (he) health_state <= health_new;
          if (de) last_drops <= cur_drops;
          if (le) begin
            last_latency      <= $signed({1'b0, lat_l});
            last_latency_time <= now;
          end
          state <= (fe || he || de || le) ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          // hold the result until the output register frees up
          if (!out_valid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      t_l       <= in_time;
      present_l <= in_present;
      frames_l  <= in_frames;
      drops_l   <= in_drops;
      lat_l     <= in_lat;
      snap_two  <= in_present && (snap_fill_next >= SFILL_W'(2));
    end
    if (state == S_RD) begin
      newest_t <= time_q;
      snap_old <= snap_q;
    end
    if (state == S_SPAN) begin
      fps_val  <= '0;
      positive <= div_start;
    end
    if (state == S_DIV && div_ctl.done) begin
      fps_val <= (32'(quot) > 32'(srhm_pkg::FPS_MAX)) ? srhm_pkg::FPS_MAX : 23'(quot);
    end
    if (state == S_MUL) begin
      prod_c   <= 48'(drop_critical) * 48'(fspan);
      prod_d   <= 48'(drop_degraded) * 48'(fspan);
      dshift   <= {dspan, 16'd0};
      fspan_nz <= (fspan != 32'd0);
    end
    if (accept && s_tuser == srhm_pkg::OP_RESET) begin
      pend.pad          <= '0;
      pend.fps_emit     <= 1'b1;
      pend.fps_q8       <= '0;
      pend.health_emit  <= 1'b1;
      pend.health       <= srhm_pkg::HEALTH_GOOD;
      pend.drops_emit   <= 1'b1;
      pend.drops        <= '0;
      pend.latency_emit <= 1'b1;
      pend.latency_out  <= srhm_pkg::LAT_UNKNOWN;
    end else if (state == S_CLASS) begin
      pend.pad          <= '0;
      pend.fps_emit     <= fe;
      pend.fps_q8       <= fe ? fps_val : 23'd0;
      pend.health_emit  <= he;
      pend.health       <= he ? health_new : srhm_pkg::HEALTH_GOOD;
      pend.drops_emit   <= de;
      pend.drops        <= de ? cur_drops : 32'd0;
      pend.latency_emit <= le;
      pend.latency_out  <= le ? $signed({1'b0, lat_l}) : 25'sd0;
    end
    if (state == S_OUT && (!out_valid || m_tready)) begin
      out_r <= pend;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_r;

  // ---------------- checks ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(FPS_WINDOW))
    else $error("frame fill beyond window");

  a_health_code: assert property (@(posedge clk) disable iff (rst)
    health_state != 2'd3)
    else $error("health state out of range");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_ctl.done |-> state == S_DIV)
    else $error("divider finished outside its state");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !m_tready) |=> state == S_OUT)
    else $error("pending result dropped");

endmodule

@@ test/stream_rate_health_monitor_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench of the stream rate health monitor: predicts each result and checks the output stream.
module stream_rate_health_monitor_unit_tb;

  localparam int RING_DEPTH  = 32;       // frame-time ring, FPS_WINDOW of the block
  localparam int SNAP_DEPTH  = 16;       // counter snapshot ring, DROP_WINDOW
  localparam int STALL_LIMIT = 5000;     // cycles without any request moving
  localparam int SETTLE      = 80;       // cycles for a tick that yields no result
  localparam int PHASE_ITEMS = 160;

  // One expected or observed result.
  typedef struct packed {
    logic              fps_emit;
    logic [22:0]       fps_q8;
    logic              health_emit;
    logic [1:0]        health;
    logic              drops_emit;
    logic [31:0]       drops;
    logic              latency_emit;
    logic signed [24:0] latency_out;
  } report_t;

  // Scoreboard: keeps its own copy of the monitor state and the pending reports.
  class health_scoreboard;
    bit [15:0] cfg [7];
    bit [31:0] frame_times [RING_DEPTH];
    int        ring_head, ring_fill;
    bit [31:0] time_base;
    bit [22:0] last_fps;
    bit [31:0] last_fps_time;
    longint    last_latency;
    bit [31:0] last_latency_time;
    bit [1:0]  health_state;
    bit [31:0] last_tick_frames, last_drops;
    bit [31:0] snap_frames [SNAP_DEPTH];
    bit [31:0] snap_drops [SNAP_DEPTH];
    int        snap_head, snap_fill;
    report_t   pending [$];
    int        failures;

    function new();
      cfg[srhm_pkg::REG_FPS_DELTA] = 26;
      cfg[srhm_pkg::REG_EMIT_MS]   = 500;
      cfg[srhm_pkg::REG_LAT_DELTA] = 128;
      cfg[srhm_pkg::REG_FPS_CRIT]  = 1280;
      cfg[srhm_pkg::REG_FPS_DEGR]  = 3840;
      cfg[srhm_pkg::REG_DROP_CRIT] = 13107;
      cfg[srhm_pkg::REG_DROP_DEGR] = 3277;
      failures = 0;
      clear_stats(0);
    endfunction

    function void clear_stats(bit [31:0] t);
      ring_head = 0; ring_fill = 0; time_base = t;
      last_fps = 0; last_fps_time = 0;
      last_latency = -256; last_latency_time = 0;
      health_state = srhm_pkg::HEALTH_GOOD;
      last_tick_frames = 0; last_drops = 0;
      snap_head = 0; snap_fill = 0;
    endfunction

    // Drop rate above thr/65536, compared without division.
    function bit rate_above(bit [31:0] num, bit [31:0] den, bit [15:0] thr);
      bit [63:0] lhs, rhs;
      lhs = {16'd0, num, 16'd0};
      rhs = 64'(thr) * 64'(den);
      return lhs > rhs;
    endfunction

    // Note an accepted request and queue the report it yields, if any.
    function void note_request(bit [1:0] op, bit [31:0] t, bit present, bit [31:0] frames,
                               bit [31:0] drops_in, bit [23:0] lat);
      report_t   r;
      bit [31:0] now, cur, span, fspan, dspan, cd, dlt;
      bit [22:0] fps;
      bit [1:0]  health;
      bit        positive, rc, rd;
      longint    q, ld;
      int        o, n;
      r = '0;
      if (op == srhm_pkg::OP_FRAME) begin
        frame_times[ring_head] = t;
        ring_head = (ring_head + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;
        return;
      end
      if (op == srhm_pkg::OP_RESET) begin
        clear_stats(t);
        r.fps_emit = 1; r.health_emit = 1; r.drops_emit = 1; r.latency_emit = 1;
        r.latency_out = -25'sd256;
        pending.push_back(r);
        return;
      end
      if (op != srhm_pkg::OP_TICK) return;   // unknown op: ignored
      now = t - time_base;
      cur = present ? frames : 32'd0;
      fps = 0; health = srhm_pkg::HEALTH_GOOD; positive = 0;
      if (cur == last_tick_frames && health_state == srhm_pkg::HEALTH_GOOD) return;  // idle skip
      last_tick_frames = cur;
      if (ring_fill >= 2) begin
        o = (ring_head + RING_DEPTH - ring_fill) % RING_DEPTH;
        n = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
        span = frame_times[n] - frame_times[o];
        if (span != 0) begin
          q = longint'(ring_fill - 1) * 256000 / longint'(span);
          fps = (q > 64'd8388607) ? srhm_pkg::FPS_MAX : q[22:0];
          positive = 1;
        end
      end
      dlt = (fps > last_fps) ? 32'(fps - last_fps) : 32'(last_fps - fps);
      if (dlt >= cfg[srhm_pkg::REG_FPS_DELTA] ||
          (now - last_fps_time) >= cfg[srhm_pkg::REG_EMIT_MS]) begin
        last_fps = fps; last_fps_time = now;
        r.fps_emit = 1; r.fps_q8 = fps;
      end
      if (present) begin
        fspan = 0; dspan = 0;
        snap_frames[snap_head] = frames;
        snap_drops[snap_head] = drops_in;
        snap_head = (snap_head + 1) % SNAP_DEPTH;
        if (snap_fill < SNAP_DEPTH) snap_fill++;
        if (snap_fill >= 2) begin
          o = (snap_head + SNAP_DEPTH - snap_fill) % SNAP_DEPTH;
          n = (snap_head + SNAP_DEPTH - 1) % SNAP_DEPTH;
          fspan = snap_frames[n] - snap_frames[o];
          dspan = snap_drops[n] - snap_drops[o];
        end
        if (positive) begin
          rc = fspan != 0 && rate_above(dspan, fspan, cfg[srhm_pkg::REG_DROP_CRIT]);
          rd = fspan != 0 && rate_above(dspan, fspan, cfg[srhm_pkg::REG_DROP_DEGR]);
          if (fps < cfg[srhm_pkg::REG_FPS_CRIT] || rc) health = srhm_pkg::HEALTH_CRITICAL;
          else if (fps < cfg[srhm_pkg::REG_FPS_DEGR] || rd) health = srhm_pkg::HEALTH_DEGRADED;
        end else if (frames != 0) begin
          health = srhm_pkg::HEALTH_CRITICAL;
        end
      end
      if (health != health_state) begin
        health_state = health;
        r.health_emit = 1; r.health = health;
      end
      cd = present ? drops_in : 32'd0;
      if (cd != last_drops) begin
        last_drops = cd;
        r.drops_emit = 1; r.drops = cd;
      end
      if (present) begin
        ld = longint'(lat) - last_latency;
        if (ld < 0) ld = -ld;
        if (ld > longint'(cfg[srhm_pkg::REG_LAT_DELTA]) ||
            (now - last_latency_time) >= cfg[srhm_pkg::REG_EMIT_MS]) begin
          last_latency = lat; last_latency_time = now;
          r.latency_emit = 1; r.latency_out = 25'(lat);
        end
      end
      if (r.fps_emit | r.health_emit | r.drops_emit | r.latency_emit) pending.push_back(r);
    endfunction

    // Compare an observed report with the oldest pending one.
    function void check_report(report_t got, realtime at);
      report_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected report %h", at, got);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.fps_emit !== want.fps_emit || got.fps_q8 !== want.fps_q8)
        $display("%0t: fps expected %0b/%0d, got %0b/%0d", at,
                 want.fps_emit, want.fps_q8, got.fps_emit, got.fps_q8);
      if (got.health_emit !== want.health_emit || got.health !== want.health)
        $display("%0t: health expected %0b/%0d, got %0b/%0d", at,
                 want.health_emit, want.health, got.health_emit, got.health);
      if (got.drops_emit !== want.drops_emit || got.drops !== want.drops)
        $display("%0t: drops expected %0b/%0d, got %0b/%0d", at,
                 want.drops_emit, want.drops, got.drops_emit, got.drops);
      if (got.latency_emit !== want.latency_emit || got.latency_out !== want.latency_out)
        $display("%0t: latency expected %0b/%0d, got %0b/%0d", at,
                 want.latency_emit, want.latency_out, got.latency_emit, got.latency_out);
      if (got !== want) failures++;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = srhm_pkg::OP_FRAME;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [87:0]  m_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  health_scoreboard sb = new();
  int  stall_cycles = 0;
  bit  hold_off_req = 0;   // ask the receiver for one long hold-off
  bit  no_idle = 0;        // phases that run both sides flat out

  // Stimulus-side model of the source: running clock and counters.
  bit [31:0] src_time, src_frames, src_drops;
  bit [23:0] src_lat;

  stream_rate_health_monitor_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Watchdog: abort when no request moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (!rst) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Check every accepted report; sample at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_report({m_tdata[0], m_tdata[23:1], m_tdata[24], m_tdata[26:25], m_tdata[27],
                       m_tdata[59:28], m_tdata[60], m_tdata[85:61]}, $realtime);
  end

  // Receiver: random stalls, plus one long hold-off on request so the block backs up.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready = 0;
        repeat (400) @(negedge clk);
        hold_off_req = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_tready = 0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Offer one request and hold it until the block takes it. Called at a falling edge.
  task automatic send_request(bit [1:0] op, bit [31:0] t, bit present, bit [31:0] frames,
                              bit [31:0] drops_in, bit [23:0] lat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  = op;
    s_tdata  = {7'd0, lat, drops_in, frames, present, t};
    s_tvalid = 1;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    sb.note_request(op, t, present, frames, drops_in, lat);
    @(negedge clk);
  endtask

  // Drain all pending reports, let a silent tick finish, then leave the input idle.
  task automatic wait_idle();
    s_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Two-phase register write; taken at the edge where the access phase is high.
  task automatic write_reg(logic [2:0] idx, bit [15:0] value);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {idx, 2'b00};
    pwdata = {16'($urandom), value};
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    sb.cfg[idx] = value;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic write_all(bit [15:0] v [7]);
    for (int i = 0; i < 7; i++) write_reg(3'(i), v[i]);
  endtask

  // A well-formed burst: some frames, then a tick carrying the source counters.
  task automatic send_burst(output int sent);
    int nframes;
    nframes = $urandom_range(1, 8);
    for (int i = 0; i < nframes; i++) begin
      src_time += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 70);
      send_request(srhm_pkg::OP_FRAME, src_time, 1'b0, '0, '0, '0);
    end
    src_frames += nframes;
    if ($urandom_range(0, 3) == 0) src_drops += $urandom_range(1, 4);
    src_lat = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                          : src_lat + 24'($urandom_range(0, 400)) - 24'd200;
    src_time += $urandom_range(0, 600);
    send_request(srhm_pkg::OP_TICK, src_time, $urandom_range(0, 9) != 0, src_frames,
                 src_drops, src_lat);
    sent = nframes + 1;
  endtask

  task automatic run_random(int target);
    int count, roll, sent;
    bit [1:0] op;
    count = 0;
    while (count < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        send_burst(sent);
        count += sent;
      end else if (roll < 78) begin
        src_time += $urandom_range(1, 100);
        send_request(srhm_pkg::OP_RESET, src_time, 1'b1, '0, '0, '0);
        count++;
      end else begin
        // noise: fully random fields, any op
        op = 2'($urandom);
        send_request(op, $urandom, 1'($urandom), $urandom, $urandom, 24'($urandom));
        if (op != 2'd3) count++;
      end
    end
  endtask

  initial begin
    bit [15:0] cfg_set [7];
    src_time = 32'd1000; src_frames = 0; src_drops = 0; src_lat = 24'd2560;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset defaults, idle skip, too few frames, zero span, unknown op,
    // time wrap, field extremes.
    send_request(srhm_pkg::OP_RESET, 32'd1000, 1'b1, '0, '0, '0);
    send_request(srhm_pkg::OP_TICK, 32'd1010, 1'b0, '0, '0, '0);            // idle: silent
    send_request(srhm_pkg::OP_TICK, 32'd1020, 1'b1, 32'd5, 32'd0, 24'd100); // no rate: critical
    send_request(srhm_pkg::OP_FRAME, 32'd1030, 1'b0, '0, '0, '0);
    send_request(srhm_pkg::OP_FRAME, 32'd1030, 1'b0, '0, '0, '0);
    send_request(srhm_pkg::OP_TICK, 32'd1040, 1'b1, 32'd7, 32'd1, 24'd100); // zero span
    send_request(2'd3, '1, 1'b1, '1, '1, '1);                               // ignored
    send_request(srhm_pkg::OP_FRAME, 32'hFFFF_FFF0, 1'b0, '0, '0, '0);
    send_request(srhm_pkg::OP_FRAME, 32'h0000_0010, 1'b0, '0, '0, '0);      // wraps
    send_request(srhm_pkg::OP_TICK, 32'h0000_0020, 1'b1, '1, '1, '1);       // counters max
    send_request(srhm_pkg::OP_TICK, 32'h0000_0030, 1'b1, '1, '1, '0);
    send_request(srhm_pkg::OP_TICK, 32'h0000_0040, 1'b0, '1, '1, '1);       // source gone
    send_request(srhm_pkg::OP_TICK, '1, 1'b1, 32'd9, 32'd9, 24'd0);
    send_request(srhm_pkg::OP_RESET, '1, 1'b0, '1, '1, '1);
    for (int i = 0; i < 4; i++) send_request(srhm_pkg::OP_FRAME, 32'd100 * i, 1'b0, '0, '0, '0);
    send_request(srhm_pkg::OP_TICK, 32'd500, 1'b1, 32'd4, 32'd0, 24'd50);
    send_request(srhm_pkg::OP_TICK, 32'd600, 1'b1, 32'd8, 32'd4, 24'd60);   // heavy drops
    send_request(srhm_pkg::OP_TICK, 32'd700, 1'b0, 32'd0, 32'd0, 24'd0);
    send_request(srhm_pkg::OP_RESET, src_time, 1'b1, '0, '0, '0);

    // Default settings, with the receiver holding off once so the input stalls.
    hold_off_req = 1;
    run_random(PHASE_ITEMS);
    wait_idle();

    // Every register at zero, flat out.
    cfg_set = '{default: 16'd0};
    write_all(cfg_set);
    no_idle = 1;
    run_random(PHASE_ITEMS / 2);
    wait_idle();

    // Every register at its maximum.
    no_idle = 0;
    cfg_set = '{default: 16'hFFFF};
    write_all(cfg_set);
    run_random(PHASE_ITEMS / 2);
    wait_idle();

    // Random settings in a useful range.
    cfg_set[srhm_pkg::REG_FPS_DELTA] = $urandom_range(0, 2000);
    cfg_set[srhm_pkg::REG_EMIT_MS]   = $urandom_range(0, 3000);
    cfg_set[srhm_pkg::REG_LAT_DELTA] = $urandom_range(0, 1000);
    cfg_set[srhm_pkg::REG_FPS_CRIT]  = $urandom_range(0, 6000);
    cfg_set[srhm_pkg::REG_FPS_DEGR]  = $urandom_range(0, 20000);
    cfg_set[srhm_pkg::REG_DROP_CRIT] = $urandom_range(0, 40000);
    cfg_set[srhm_pkg::REG_DROP_DEGR] = $urandom_range(0, 10000);
    write_all(cfg_set);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Back to defaults.
    cfg_set = '{16'd26, 16'd500, 16'd128, 16'd1280, 16'd3840, 16'd13107, 16'd3277};
    write_all(cfg_set);
    run_random(PHASE_ITEMS / 2);
    wait_idle();

    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/srhm_pkg.sv
rtl/core/srhm_div.sv
rtl/core/stream_rate_health_monitor_unit.sv
test/stream_rate_health_monitor_unit_tb.sv
